// ===== sv/dct2d_unnormalized_block_assert.svh =====
// Assertion macros shared by the 2D DCT block modules.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef DCT2D_UNNORMALIZED_BLOCK_ASSERT_SVH
`define DCT2D_UNNORMALIZED_BLOCK_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define DCT2D_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define DCT2D_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dct2d_pkg.sv =====
// Shared constants, types and cosine table for the 2D DCT block.
// Used by every module of the block except the generic RAM; depends on nothing else.
package dct2d_pkg;

    // Block geometry.
    localparam int ROWS   = 8;
    localparam int COLS   = 8;
    localparam int BLK    = ROWS * COLS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ADDR_W = $clog2(BLK);
    // Cosine table index; the row and column transforms have the same length.
    localparam int CIDX_W = $clog2(4 * COLS);

    // Data widths.
    localparam int SAMPLE_W = 12;
    localparam int ROWV_W   = 24;
    localparam int COEF_W   = 18;
    localparam int IDX_W    = 3;
    localparam int COS_W    = 16;
    localparam int PROD_W   = ROWV_W + COS_W;
    localparam int ACC_W    = PROD_W + COL_W;

    // Rounding shifts: Q14 to Q4 after the row pass, Q18 to integer after the column pass.
    localparam int ROW_SHIFT = 10;
    localparam int COL_SHIFT = 18;

    // Output transfer bookkeeping: results reserved but not yet delivered.
    localparam int CRD_MAX = 2;
    localparam int CRD_W   = 2;

    // cos(pi * a / 16) in Q1.14, rounded to nearest.
    localparam logic signed [COS_W-1:0] COS_TAB [4*COLS] = '{
        16'sd16384,  16'sd16069,  16'sd15137,  16'sd13623,
        16'sd11585,  16'sd9102,   16'sd6270,   16'sd3196,
        16'sd0,     -16'sd3196,  -16'sd6270,  -16'sd9102,
        -16'sd11585, -16'sd13623, -16'sd15137, -16'sd16069,
        -16'sd16384, -16'sd16069, -16'sd15137, -16'sd13623,
        -16'sd11585, -16'sd9102,  -16'sd6270,  -16'sd3196,
        16'sd0,      16'sd3196,   16'sd6270,   16'sd9102,
        16'sd11585,  16'sd13623,  16'sd15137,  16'sd16069
    };

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROW,
        ST_ROW_DRAIN,
        ST_COL,
        ST_COL_DRAIN
    } state_t;

    // One product term issued by the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic              col_pass;
        logic [CIDX_W-1:0] cos_idx;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              blk_last;
    } issue_t;

    // One finished sum, rounded and saturated for its pass.
    typedef struct packed {
        logic                     valid;
        logic                     col_pass;
        logic [ROW_W-1:0]         row;
        logic [COL_W-1:0]         col;
        logic                     blk_last;
        logic signed [ROWV_W-1:0] value;
    } result_t;

    // Cosine table index ((2 * pos + 1) * freq) mod 4N.
    function automatic logic [CIDX_W-1:0] cos_index(input logic [COL_W-1:0] pos,
                                                    input logic [COL_W-1:0] freq);
        logic [2*COL_W:0] t;
        t = {pos, 1'b1} * {1'b0, freq};
        return t[CIDX_W-1:0];
    endfunction

endpackage

// ===== sv/dct2d_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered; contents are not reset.
module dct2d_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dct2d_mac.sv =====
// Shared multiply-accumulate unit: cosine lookup, product, sum, round and saturate.
// Uses dct2d_pkg; operands come from the registered read ports of the two stores.
`include "dct2d_unnormalized_block_assert.svh"

module dct2d_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dct2d_pkg::issue_t                      issue,
    input  logic [dct2d_pkg::SAMPLE_W-1:0]         sample_rdata,
    input  logic [dct2d_pkg::ROWV_W-1:0]           row_rdata,
    output dct2d_pkg::result_t                     result,
    output logic                                   busy
);

    localparam int ACC_W  = dct2d_pkg::ACC_W;
    localparam int ROWV_W = dct2d_pkg::ROWV_W;

    localparam logic signed [ACC_W-1:0] ROWV_HI =
        ACC_W'((64'sd1 <<< (dct2d_pkg::ROWV_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] ROWV_LO = -ROWV_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] COEF_HI =
        ACC_W'((64'sd1 <<< (dct2d_pkg::COEF_W - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] COEF_LO = -COEF_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ROW_HALF =
        ACC_W'(64'sd1 <<< (dct2d_pkg::ROW_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] COL_HALF =
        ACC_W'(64'sd1 <<< (dct2d_pkg::COL_SHIFT - 1));

    dct2d_pkg::issue_t  s1_reg, s2_reg, s3_reg;
    dct2d_pkg::result_t res_reg, res_next;

    logic signed [ROWV_W-1:0]                  operand;
    logic signed [dct2d_pkg::COS_W-1:0]        cos_val;
    logic signed [dct2d_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic signed [ACC_W-1:0]                   acc_reg, acc_next;
    logic signed [ACC_W-1:0]                   rnd_row, rnd_col, sat_val;

    // Control follows the data through the memory read, multiply and accumulate stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            s3_reg  <= '0;
            res_reg <= '0;
        end
        else
        begin
            s1_reg  <= issue;
            s2_reg  <= s1_reg;
            s3_reg  <= s2_reg;
            res_reg <= res_next;
        end
    end

    // Operand select and cosine lookup while the store read data is valid.
    always_comb
    begin
        if (s1_reg.col_pass)
        begin
            operand = $signed(row_rdata);
        end
        else
        begin
            operand = ROWV_W'($signed(sample_rdata));
        end
        cos_val   = dct2d_pkg::COS_TAB[s1_reg.cos_idx];
        prod_next = operand * cos_val;
    end

    // Accumulate: the first term of a sum restarts the accumulator.
    always_comb
    begin
        if (s2_reg.first)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (s2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    // Round to nearest (ties up) and saturate once the last term is in.
    always_comb
    begin
        rnd_row = (acc_reg + ROW_HALF) >>> dct2d_pkg::ROW_SHIFT;
        rnd_col = (acc_reg + COL_HALF) >>> dct2d_pkg::COL_SHIFT;
        if (s3_reg.col_pass)
        begin
            if (rnd_col > COEF_HI)
            begin
                sat_val = COEF_HI;
            end
            else if (rnd_col < COEF_LO)
            begin
                sat_val = COEF_LO;
            end
            else
            begin
                sat_val = rnd_col;
            end
        end
        else
        begin
            if (rnd_row > ROWV_HI)
            begin
                sat_val = ROWV_HI;
            end
            else if (rnd_row < ROWV_LO)
            begin
                sat_val = ROWV_LO;
            end
            else
            begin
                sat_val = rnd_row;
            end
        end
        res_next.valid    = s3_reg.valid && s3_reg.last;
        res_next.col_pass = s3_reg.col_pass;
        res_next.row      = s3_reg.row;
        res_next.col      = s3_reg.col;
        res_next.blk_last = s3_reg.blk_last;
        res_next.value    = ROWV_W'(sat_val);
    end

    assign result = res_reg;
    assign busy   = s1_reg.valid || s2_reg.valid || s3_reg.valid || res_reg.valid;

    // A column term must never share the pipeline with a row term still in flight.
    `DCT2D_ASSERT_ALWAYS(a_no_pass_mix, !(s1_reg.valid && s1_reg.col_pass && ((s2_reg.valid && !s2_reg.col_pass) || (s3_reg.valid && !s3_reg.col_pass))), "row and column terms mixed in the pipeline")
    // The terms of one sum arrive in consecutive cycles.
    `DCT2D_ASSERT_NEXT(a_terms_contiguous, s2_reg.valid && !s2_reg.last, s2_reg.valid && !s2_reg.first, "gap or restart inside one sum")

endmodule

// ===== sv/dct2d_outq.sv =====
// Two-entry output queue that holds finished coefficients until the sink takes them.
// Uses dct2d_pkg for the result type.
`include "dct2d_unnormalized_block_assert.svh"

module dct2d_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dct2d_pkg::result_t push_data,
    input  logic               pop,
    output logic               head_valid,
    output dct2d_pkg::result_t head
);

    dct2d_pkg::result_t ent_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (cnt_reg != 2'd0);
    assign head       = ent_reg[rd_ptr_reg];

    // The reservation scheme upstream must keep the queue from overflowing.
    `DCT2D_ASSERT_ALWAYS(a_q_no_overflow, !(push && cnt_reg == 2'd2 && !pop), "output queue overflow")

endmodule

// ===== sv/dct2d_seq.sv =====
// Sequencer: sample loading, row and column pass address generation, output reservations.
// Uses dct2d_pkg; drives the store addresses and the multiply-accumulate issue.
`include "dct2d_unnormalized_block_assert.svh"

module dct2d_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load_xfer,
    input  logic                              mac_busy,
    input  logic                              out_xfer,
    output logic                              load_ready,
    output logic [dct2d_pkg::ADDR_W-1:0]      load_addr,
    output logic [dct2d_pkg::ADDR_W-1:0]      sample_raddr,
    output logic [dct2d_pkg::ADDR_W-1:0]      row_raddr,
    output dct2d_pkg::issue_t                 issue
);

    localparam int ADDR_W = dct2d_pkg::ADDR_W;
    localparam int ROW_W  = dct2d_pkg::ROW_W;
    localparam int COL_W  = dct2d_pkg::COL_W;
    localparam int CRD_W  = dct2d_pkg::CRD_W;

    dct2d_pkg::state_t  state_reg, state_next;
    logic [ADDR_W-1:0]  load_pos_reg, load_pos_next;
    logic [ROW_W-1:0]   o_reg, o_next;
    logic [COL_W-1:0]   k_reg, k_next;
    logic [COL_W-1:0]   n_reg, n_next;
    logic [CRD_W-1:0]   crd_reg, crd_next;
    logic               start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dct2d_pkg::ST_LOAD;
            load_pos_reg <= '0;
            o_reg        <= '0;
            k_reg        <= '0;
            n_reg        <= '0;
            crd_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            o_reg        <= o_next;
            k_reg        <= k_next;
            n_reg        <= n_next;
            crd_reg      <= crd_next;
        end
    end

    // Store addresses: row pass reads x[o][n], column pass reads r[n][k].
    always_comb
    begin
        sample_raddr = ADDR_W'(int'(o_reg) * dct2d_pkg::COLS + int'(n_reg));
        row_raddr    = ADDR_W'(int'(n_reg) * dct2d_pkg::COLS + int'(k_reg));
        load_addr    = load_pos_reg;
    end

    // Next state, counters and issue.
    always_comb
    begin
        state_next    = state_reg;
        load_pos_next = load_pos_reg;
        o_next        = o_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        load_ready    = 1'b0;
        issue         = '0;
        start         = 1'b0;

        case (state_reg)
            dct2d_pkg::ST_LOAD:
            begin
                load_ready = 1'b1;
                if (load_xfer)
                begin
                    if (load_pos_reg == ADDR_W'(dct2d_pkg::BLK - 1))
                    begin
                        load_pos_next = '0;
                        o_next        = '0;
                        k_next        = '0;
                        n_next        = '0;
                        state_next    = dct2d_pkg::ST_ROW;
                    end
                    else
                    begin
                        load_pos_next = load_pos_reg + ADDR_W'(1);
                    end
                end
            end

            dct2d_pkg::ST_ROW:
            begin
                // One product per cycle: row o, frequency k, sample n.
                issue.valid    = 1'b1;
                issue.first    = (n_reg == '0);
                issue.last     = (n_reg == COL_W'(dct2d_pkg::COLS - 1));
                issue.col_pass = 1'b0;
                issue.cos_idx  = dct2d_pkg::cos_index(n_reg, k_reg);
                issue.row      = o_reg;
                issue.col      = k_reg;
                issue.blk_last = 1'b0;
                if (n_reg == COL_W'(dct2d_pkg::COLS - 1))
                begin
                    n_next = '0;
                    if (k_reg == COL_W'(dct2d_pkg::COLS - 1))
                    begin
                        k_next = '0;
                        if (o_reg == ROW_W'(dct2d_pkg::ROWS - 1))
                        begin
                            o_next     = '0;
                            state_next = dct2d_pkg::ST_ROW_DRAIN;
                        end
                        else
                        begin
                            o_next = o_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        k_next = k_reg + COL_W'(1);
                    end
                end
                else
                begin
                    n_next = n_reg + COL_W'(1);
                end
            end

            dct2d_pkg::ST_ROW_DRAIN:
            begin
                // Interlock: every row result is written before the column pass reads.
                if (!mac_busy)
                begin
                    state_next = dct2d_pkg::ST_COL;
                end
            end

            dct2d_pkg::ST_COL:
            begin
                // A new coefficient starts only when an output slot is reserved for it.
                if ((n_reg != '0) || (crd_reg < CRD_W'(dct2d_pkg::CRD_MAX)))
                begin
                    start          = (n_reg == '0);
                    issue.valid    = 1'b1;
                    issue.first    = (n_reg == '0);
                    issue.last     = (n_reg == COL_W'(dct2d_pkg::ROWS - 1));
                    issue.col_pass = 1'b1;
                    issue.cos_idx  = dct2d_pkg::cos_index(n_reg, COL_W'(o_reg));
                    issue.row      = o_reg;
                    issue.col      = k_reg;
                    issue.blk_last = (o_reg == ROW_W'(dct2d_pkg::ROWS - 1))
                                     && (k_reg == COL_W'(dct2d_pkg::COLS - 1));
                    if (n_reg == COL_W'(dct2d_pkg::ROWS - 1))
                    begin
                        n_next = '0;
                        if (k_reg == COL_W'(dct2d_pkg::COLS - 1))
                        begin
                            k_next = '0;
                            if (o_reg == ROW_W'(dct2d_pkg::ROWS - 1))
                            begin
                                o_next     = '0;
                                state_next = dct2d_pkg::ST_COL_DRAIN;
                            end
                            else
                            begin
                                o_next = o_reg + ROW_W'(1);
                            end
                        end
                        else
                        begin
                            k_next = k_reg + COL_W'(1);
                        end
                    end
                    else
                    begin
                        n_next = n_reg + COL_W'(1);
                    end
                end
            end

            dct2d_pkg::ST_COL_DRAIN:
            begin
                // Wait until every coefficient of the block has been transferred.
                if (crd_reg == '0)
                begin
                    state_next = dct2d_pkg::ST_LOAD;
                end
            end

            default:
            begin
                state_next = dct2d_pkg::ST_LOAD;
            end
        endcase
    end

    // Reservations: taken when a coefficient starts, returned on its output transfer.
    always_comb
    begin
        crd_next = crd_reg;
        if (start && !out_xfer)
        begin
            crd_next = crd_reg + CRD_W'(1);
        end
        else if (out_xfer && !start)
        begin
            crd_next = crd_reg - CRD_W'(1);
        end
    end

    `DCT2D_ASSERT_ALWAYS(a_crd_max, crd_reg <= CRD_W'(dct2d_pkg::CRD_MAX), "output reservations exceed queue depth")
    `DCT2D_ASSERT_ALWAYS(a_xfer_reserved, !(out_xfer && crd_reg == '0), "output transfer without a reservation")

endmodule

// ===== sv/dct2d_unnormalized_block.sv =====
// Unnormalized 8x8 2D DCT-II: 64 samples in, 64 coefficients out, row-major.
// Samples are written to the sample store in the load state; the transform uses one
// multiply-accumulate doing 1024 products, one per cycle unless the column pass waits
// for an output reservation. The next block's samples are accepted only after every
// coefficient of the current block has been transferred, so sink stalls delay them.
// Reset clears the sequencer, load position and output queue; stores are not cleared.
module dct2d_unnormalized_block (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [17:0] coefficient, [20:18] row_index, [23:21] col_index
    output logic        m_axis_tlast    // last_of_block
);

    dct2d_pkg::issue_t                 issue;
    dct2d_pkg::result_t                result;
    dct2d_pkg::result_t                head;
    logic                              load_xfer;
    logic                              out_xfer;
    logic                              mac_busy;
    logic                              head_valid;
    logic [dct2d_pkg::ADDR_W-1:0]      load_addr;
    logic [dct2d_pkg::ADDR_W-1:0]      sample_raddr;
    logic [dct2d_pkg::ADDR_W-1:0]      row_raddr;
    logic [dct2d_pkg::ADDR_W-1:0]      row_waddr;
    logic [dct2d_pkg::SAMPLE_W-1:0]    sample_rdata;
    logic [dct2d_pkg::ROWV_W-1:0]      row_rdata;

    assign load_xfer = s_axis_tvalid && s_axis_tready;
    assign out_xfer  = m_axis_tvalid && m_axis_tready;

    dct2d_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_xfer    (load_xfer),
        .mac_busy     (mac_busy),
        .out_xfer     (out_xfer),
        .load_ready   (s_axis_tready),
        .load_addr    (load_addr),
        .sample_raddr (sample_raddr),
        .row_raddr    (row_raddr),
        .issue        (issue)
    );

    // Sample store: written by input transfers, read by the row pass.
    dct2d_ram #(
        .WIDTH (dct2d_pkg::SAMPLE_W),
        .DEPTH (dct2d_pkg::BLK)
    ) u_sample_ram (
        .clk   (clk),
        .we    (load_xfer),
        .waddr (load_addr),
        .wdata (s_axis_tdata[dct2d_pkg::SAMPLE_W-1:0]),
        .raddr (sample_raddr),
        .rdata (sample_rdata)
    );

    // Row pass store: written with row results, read by the column pass.
    assign row_waddr = dct2d_pkg::ADDR_W'(int'(result.row) * dct2d_pkg::COLS
                                          + int'(result.col));

    dct2d_ram #(
        .WIDTH (dct2d_pkg::ROWV_W),
        .DEPTH (dct2d_pkg::BLK)
    ) u_row_ram (
        .clk   (clk),
        .we    (result.valid && !result.col_pass),
        .waddr (row_waddr),
        .wdata (result.value),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    dct2d_mac u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (issue),
        .sample_rdata (sample_rdata),
        .row_rdata    (row_rdata),
        .result       (result),
        .busy         (mac_busy)
    );

    dct2d_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (result.valid && result.col_pass),
        .push_data  (result),
        .pop        (out_xfer),
        .head_valid (head_valid),
        .head       (head)
    );

    // Output stream packing.
    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = {head.col[dct2d_pkg::IDX_W-1:0],
                            head.row[dct2d_pkg::IDX_W-1:0],
                            head.value[dct2d_pkg::COEF_W-1:0]};
    assign m_axis_tlast  = head.blk_last;

endmodule
